// File: src/i2cms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants of the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    localparam int DELAY_BITS = 16;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd100;
    localparam logic [7:0]  SAMPLE_DELAY_RESET = 8'd10;
    localparam logic [7:0]  POLL_LIMIT_RESET = 8'd250;

    localparam logic [1:0] REG_HALF_PERIOD  = 2'd0;
    localparam logic [1:0] REG_SAMPLE_DELAY = 2'd1;
    localparam logic [1:0] REG_POLL_LIMIT   = 2'd2;

    typedef enum logic [2:0] {
        ACT_START = 3'd0,
        ACT_STOP  = 3'd1,
        ACT_ACK   = 3'd2,
        ACT_NACK  = 3'd3,
        ACT_WAIT  = 3'd4,
        ACT_WRITE = 3'd5,
        ACT_READ  = 3'd6
    } i2cms_action_t;

    typedef struct packed {
        logic [15:0] half_period_ticks;
        logic [7:0]  sample_delay_ticks;
        logic [7:0]  ack_poll_limit;
    } i2cms_cfg_t;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] action;
        logic [7:0] byte_in;
        logic       sda_in;
    } i2cms_cmd_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] byte_out;
        logic       ack_missing;
    } i2cms_res_t;

endpackage

// File: src/i2cms_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_step
// Line phase state machine: advances one tick for each word it is given.
// ----------------------------------------------------------------------------
module i2cms_step
    import i2cms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  i2cms_cmd_t cmd,
    input  i2cms_cfg_t cfg,
    output i2cms_res_t res_next
);

    typedef enum logic [3:0] {
        P_IDLE, P_ST_A, P_ST_B, P_SP_A, P_SP_B, P_AK_A, P_AK_B,
        P_WA_A, P_WA_B, P_POLL, P_WR_A, P_WR_B, P_WR_C, P_RD_A, P_RD_B
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [3:0]              bit_count_reg, bit_count_next;
    logic [7:0]              shift_reg, shift_next;
    logic [DELAY_BITS-1:0]   delay_reg, delay_next;
    logic [7:0]              poll_reg, poll_next;
    logic                    scl_reg, scl_next;
    logic                    sda_reg, sda_next;
    logic                    timeout_reg, timeout_next;
    logic [7:0]              rx_hold_reg, rx_hold_next;
    logic                    done;
    logic [DELAY_BITS-1:0]   hp_ticks;
    logic [DELAY_BITS-1:0]   sd_ticks;
    logic [3:0]              bit_count_inc;
    logic [7:0]              shift_rx;

    // A zero count acts as one; a count beyond the delay counter saturates.
    function automatic logic [DELAY_BITS-1:0] load_ticks(input logic [15:0] t);
        logic [32:0] w;
        logic [32:0] top;
        w = (t == 16'd0) ? 33'd1 : {17'd0, t};
        top = (33'd1 << DELAY_BITS) - 33'd1;
        if (w > top)
            w = top;
        return w[DELAY_BITS-1:0];
    endfunction

    assign hp_ticks      = load_ticks(cfg.half_period_ticks);
    assign sd_ticks      = load_ticks({8'd0, cfg.sample_delay_ticks});
    assign bit_count_inc = bit_count_reg + 4'd1;
    assign shift_rx      = {shift_reg[6:0], cmd.sda_in};

    always_comb
    begin
        phase_next     = phase_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        delay_next     = delay_reg;
        poll_next      = poll_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        timeout_next   = timeout_reg;
        rx_hold_next   = rx_hold_reg;
        done           = 1'b0;

        if (phase_reg == P_IDLE)
        begin
            if (cmd.cmd_valid)
            begin
                case (cmd.action)
                    ACT_START:
                    begin
                        sda_next = 1'b1; scl_next = 1'b1;
                        phase_next = P_ST_A; delay_next = hp_ticks;
                    end
                    ACT_STOP:
                    begin
                        scl_next = 1'b0; sda_next = 1'b0;
                        phase_next = P_SP_A; delay_next = hp_ticks;
                    end
                    ACT_ACK:
                    begin
                        scl_next = 1'b0; sda_next = 1'b0;
                        phase_next = P_AK_A; delay_next = hp_ticks;
                    end
                    ACT_NACK:
                    begin
                        scl_next = 1'b0; sda_next = 1'b1;
                        phase_next = P_AK_A; delay_next = hp_ticks;
                    end
                    ACT_WAIT:
                    begin
                        timeout_next = 1'b0; poll_next = 8'd0; sda_next = 1'b1;
                        phase_next = P_WA_A; delay_next = hp_ticks;
                    end
                    ACT_WRITE:
                    begin
                        shift_next = cmd.byte_in; bit_count_next = 4'd0;
                        scl_next = 1'b0;
                        phase_next = P_WR_A; delay_next = hp_ticks;
                    end
                    ACT_READ:
                    begin
                        shift_next = 8'd0; bit_count_next = 4'd0;
                        sda_next = 1'b1; scl_next = 1'b0;
                        phase_next = P_RD_A; delay_next = hp_ticks;
                    end
                    default:
                    begin
                        phase_next = P_IDLE;
                    end
                endcase
            end
        end
        else if (phase_reg == P_POLL)
        begin
            if (!cmd.sda_in)
            begin
                scl_next = 1'b0; phase_next = P_IDLE; done = 1'b1;
            end
            else if (poll_reg >= cfg.ack_poll_limit)
            begin
                timeout_next = 1'b1; scl_next = 1'b0; sda_next = 1'b0;
                phase_next = P_SP_A; delay_next = hp_ticks;
            end
            else
            begin
                poll_next = poll_reg + 8'd1;
            end
        end
        else if (delay_reg > DELAY_BITS'(1))
        begin
            delay_next = delay_reg - DELAY_BITS'(1);
        end
        else
        begin
            case (phase_reg)
                P_ST_A:
                begin
                    sda_next = 1'b0; phase_next = P_ST_B; delay_next = hp_ticks;
                end
                P_ST_B:
                begin
                    scl_next = 1'b0; phase_next = P_IDLE; done = 1'b1;
                end
                P_SP_A:
                begin
                    scl_next = 1'b1; sda_next = 1'b1;
                    phase_next = P_SP_B; delay_next = hp_ticks;
                end
                P_SP_B:
                begin
                    phase_next = P_IDLE; done = 1'b1;
                end
                P_AK_A:
                begin
                    scl_next = 1'b1; phase_next = P_AK_B; delay_next = hp_ticks;
                end
                P_AK_B:
                begin
                    scl_next = 1'b0; phase_next = P_IDLE; done = 1'b1;
                end
                P_WA_A:
                begin
                    scl_next = 1'b1; phase_next = P_WA_B; delay_next = hp_ticks;
                end
                P_WA_B:
                begin
                    phase_next = P_POLL; delay_next = '0;
                end
                P_WR_A:
                begin
                    sda_next = shift_reg[7];
                    shift_next = {shift_reg[6:0], 1'b0};
                    phase_next = P_WR_B; delay_next = hp_ticks;
                end
                P_WR_B:
                begin
                    scl_next = 1'b1; phase_next = P_WR_C; delay_next = hp_ticks;
                end
                P_WR_C:
                begin
                    bit_count_next = bit_count_inc;
                    scl_next = 1'b0;
                    if (bit_count_inc >= 4'd8)
                    begin
                        phase_next = P_IDLE; done = 1'b1;
                    end
                    else
                    begin
                        phase_next = P_WR_A; delay_next = hp_ticks;
                    end
                end
                P_RD_A:
                begin
                    scl_next = 1'b1; phase_next = P_RD_B; delay_next = sd_ticks;
                end
                P_RD_B:
                begin
                    shift_next = shift_rx;
                    bit_count_next = bit_count_inc;
                    scl_next = 1'b0;
                    if (bit_count_inc >= 4'd8)
                    begin
                        rx_hold_next = shift_rx; phase_next = P_IDLE; done = 1'b1;
                    end
                    else
                    begin
                        phase_next = P_RD_A; delay_next = hp_ticks;
                    end
                end
                default:
                begin
                    phase_next = P_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        res_next.scl_out     = scl_next;
        res_next.sda_out     = sda_next;
        res_next.busy_res    = (phase_next != P_IDLE);
        res_next.done_res    = done;
        res_next.byte_out    = rx_hold_next;
        res_next.ack_missing = timeout_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= P_IDLE;
            bit_count_reg <= 4'd0;
            shift_reg     <= 8'd0;
            delay_reg     <= '0;
            poll_reg      <= 8'd0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            timeout_reg   <= 1'b0;
            rx_hold_reg   <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            delay_reg     <= delay_next;
            poll_reg      <= poll_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            timeout_reg   <= timeout_next;
            rx_hold_reg   <= rx_hold_next;
        end
    end

endmodule

// File: src/i2c_master_bit_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// I2C master line sequencer driven by one timing tick per input word.
// ----------------------------------------------------------------------------
// Each word on the s_axis channel is one tick: an optional command in tuser
// and the sampled SDA level with the byte to write in tdata. Every accepted
// word yields exactly one result word on the m_axis channel carrying the SCL
// and SDA drives, busy, the done pulse, the last read byte and the no-ack flag.
// A word is held in the input register on entry and its result in the output
// register on exit. One word is taken in every cycle while the receiver does
// not stall; the tick state machine advances once per word. When the receiver
// stalls, the output register holds its word and the input register holds
// one more; tready then drops until the result is taken. Reset releases both
// lines, clears all counters and flags, restores the default timing registers
// and empties both registers. Timing registers are written through cfg_we/
// cfg_addr/cfg_wdata, by the user only while idle; the block does not check.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer
    import i2cms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // byte_in[7:0], sda_in[8], zero pad
    input  logic [3:0]  s_axis_tuser,   // cmd_valid[0], action[3:1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // scl_out, sda_out, busy_res, done_res,
                                        // byte_out[11:4], ack_missing[12], pad
);

    i2cms_cfg_t cfg_reg;
    i2cms_cmd_t in_reg;
    logic       in_valid_reg;
    i2cms_res_t out_reg;
    logic       out_valid_reg;
    i2cms_res_t res_next;
    logic       advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period_ticks  <= HALF_PERIOD_RESET;
            cfg_reg.sample_delay_ticks <= SAMPLE_DELAY_RESET;
            cfg_reg.ack_poll_limit     <= POLL_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_HALF_PERIOD:  cfg_reg.half_period_ticks  <= cfg_wdata;
                REG_SAMPLE_DELAY: cfg_reg.sample_delay_ticks <= cfg_wdata[7:0];
                REG_POLL_LIMIT:   cfg_reg.ack_poll_limit     <= cfg_wdata[7:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_reg.cmd_valid <= s_axis_tuser[0];
            in_reg.action    <= s_axis_tuser[3:1];
            in_reg.byte_in   <= s_axis_tdata[7:0];
            in_reg.sda_in    <= s_axis_tdata[8];
        end
        if (advance)
        begin
            out_reg <= res_next;
        end
    end

    i2cms_step u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .cmd      (in_reg),
        .cfg      (cfg_reg),
        .res_next (res_next)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0, out_reg.ack_missing, out_reg.byte_out,
                            out_reg.done_res, out_reg.busy_res,
                            out_reg.sda_out, out_reg.scl_out};

`ifndef SYNTHESIS
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[3]) |-> !m_axis_tdata[2])
        else $error("done reported while still busy");

    a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without an output stall");

    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_axis_tvalid) |-> $past(m_axis_tready))
        else $error("result word dropped before it was taken");
`endif

endmodule
